### src/assert_macros.svh
// Assertion macros shared by the exponential pipeline modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(lbl, clk_sig, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

### src/etra_pkg.sv
// Package with formats, constants, the root table and multiply helpers of the exp pipeline.
package etra_pkg;

	localparam int INPUT_FRAC_BITS = 16;
	localparam int MANT_FRAC_BITS  = 30;
	localparam int X_WIDTH         = 22;
	localparam int WORK_BITS       = 56;
	localparam int RED_BITS        = 44;
	localparam int TAB_BITS        = 62;
	localparam int DIV_STAGES      = WORK_BITS;
	localparam int DIV_W           = WORK_BITS + 3;
	localparam int RND_SH          = TAB_BITS + WORK_BITS - MANT_FRAC_BITS - 64;

	localparam logic [127:0] S15 = 128'd1000000000000000;
	localparam logic [127:0] S17 = 128'd100000000000000000;

	// 16/ln2 with 32 fractional bits and ln2/16 with RED_BITS fractional bits.
	localparam logic [63:0] K32 = 64'((128'd23083120654223414 << 32) / S15);
	localparam logic [63:0] C44 = 64'((128'd43321698784997 << RED_BITS) / S15);

	localparam logic [63:0] ONE_W = 64'd1 << WORK_BITS;

	// Reciprocals for exact floor division of r^2 (below 2^(WORK_BITS-8)) and r^4.
	localparam int SH42  = WORK_BITS - 2;
	localparam int SH6   = WORK_BITS - 5;
	localparam int SH840 = WORK_BITS - 6;
	localparam logic [63:0] M42  = 64'(((128'd1 << SH42) + 128'd41) / 128'd42);
	localparam logic [63:0] M6   = 64'(((128'd1 << SH6) + 128'd5) / 128'd6);
	localparam logic [63:0] M840 = 64'(((128'd1 << SH840) + 128'd839) / 128'd840);

	// 2^(k/16) with TAB_BITS fractional bits.
	localparam logic [63:0] ROOT_TAB [16] = '{
		64'((128'd100000000000000000 << TAB_BITS) / S17),
		64'((128'd104427378242741380 << TAB_BITS) / S17),
		64'((128'd109050773266525770 << TAB_BITS) / S17),
		64'((128'd113878863475669160 << TAB_BITS) / S17),
		64'((128'd118920711500272100 << TAB_BITS) / S17),
		64'((128'd124185781207348400 << TAB_BITS) / S17),
		64'((128'd129683955465100960 << TAB_BITS) / S17),
		64'((128'd135425554693689270 << TAB_BITS) / S17),
		64'((128'd141421356237309510 << TAB_BITS) / S17),
		64'((128'd147682614593949930 << TAB_BITS) / S17),
		64'((128'd154221082540794070 << TAB_BITS) / S17),
		64'((128'd161049033194925430 << TAB_BITS) / S17),
		64'((128'd168179283050742900 << TAB_BITS) / S17),
		64'((128'd175625216037329950 << TAB_BITS) / S17),
		64'((128'd183400808640934240 << TAB_BITS) / S17),
		64'((128'd191520656139714740 << TAB_BITS) / S17)
	};

	typedef struct packed {
		logic [63:0] ll;
		logic [63:0] lh;
		logic [63:0] hl;
		logic [63:0] hh;
	} pp_t;

	typedef struct packed {
		logic       rneg;
		logic [3:0] idx;
		logic [6:0] sh;
	} side_t;

	// Four 32x32 partial products of a 64x64 multiply.
	function automatic pp_t pp_make(logic [63:0] a, logic [63:0] b);
		pp_t p;
		p.ll = a[31:0] * b[31:0];
		p.lh = a[31:0] * b[63:32];
		p.hl = a[63:32] * b[31:0];
		p.hh = a[63:32] * b[63:32];
		return p;
	endfunction

	function automatic logic [127:0] pp_sum(pp_t p);
		return {64'd0, p.ll} + ({64'd0, p.lh} << 32) + ({64'd0, p.hl} << 32) + {p.hh, 64'd0};
	endfunction

endpackage

### src/etra_div.sv
// Pipelined restoring divider, one quotient bit per stage, fractional quotient only.
`include "assert_macros.svh"

module etra_div import etra_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DIV_W-1:0]       num,
	input  logic [DIV_W-1:0]       den,
	input  side_t                  in_side,
	output logic                   out_valid,
	output logic [WORK_BITS-1:0]   quo,
	output side_t                  out_side
);

	logic                 vld_s  [1:DIV_STAGES];
	logic [DIV_W-1:0]     rem_s  [1:DIV_STAGES];
	logic [DIV_W-1:0]     den_s  [1:DIV_STAGES];
	logic [WORK_BITS-1:0] q_s    [1:DIV_STAGES];
	side_t                side_s [1:DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic                 vld_in;
		logic [DIV_W-1:0]     rem_in;
		logic [DIV_W-1:0]     den_in;
		logic [WORK_BITS-1:0] q_in;
		side_t                side_in;
		logic [DIV_W-1:0]     rem2;
		logic                 take;

		// The first stage works on the divider inputs, later ones on the stage before.
		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = num;
			assign den_in  = den;
			assign q_in    = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k];
			assign rem_in  = rem_s[k];
			assign den_in  = den_s[k];
			assign q_in    = q_s[k];
			assign side_in = side_s[k];
		end

		assign rem2 = {rem_in[DIV_W-2:0], 1'b0};
		assign take = rem2 >= den_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem2 - den_in : rem2;
				den_s[k+1]  <= den_in;
				q_s[k+1]    <= {q_in[WORK_BITS-2:0], take};
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign quo       = q_s[DIV_STAGES];
	assign out_side  = side_s[DIV_STAGES];

	// The partial remainder stays below the divisor at the last stage.
	`ASSERT_STD(a_rem_below_den, vld_s[DIV_STAGES] |-> rem_s[DIV_STAGES] < den_s[DIV_STAGES], "divider remainder not reduced")

endmodule

### src/exp_table_rational_approx.sv
// Top level of the pipelined e^x unit: range reduction, rational core and table scaling.
//
//  Channel  Direction  Signals                    Contents
//  s_axis   in         s_tvalid s_tready s_tdata  x_value (Q6.16) per transfer
//  m_axis   out        m_tvalid m_tready m_tdata  power_shift and mantissa per transfer
//
// One transfer enters per cycle and one result leaves per cycle while results are taken.
// The pipe has 15 stages of reduction and rational setup, 56 stages of the
// one-bit-per-stage divider and 4 stages of scaling.
// The whole pipe advances together; when the output register is full and not taken,
// every stage holds and s_tready drops, so nothing is lost or repeated.
// Reset clears only the valid bits; the payload registers are not reset.
`include "assert_macros.svh"

module exp_table_rational_approx import etra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [21:0] x_value, [23:22] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [6:0] power_shift, [38:7] mantissa, [39] zero
);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Valid bits of the stages around the divider.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19;
	logic div_valid;

	// Payload registers.
	logic [X_WIDTH-1:0] x_s1;
	logic [X_WIDTH-1:0] ax_s2, ax_s3, ax_s4, ax_s5, ax_s6;
	logic xneg_s2, xneg_s3, xneg_s4, xneg_s5, xneg_s6, xneg_s7;
	pp_t         pa_s3, pb_s5, pr_s9, p42_s11, p6_s11, prr_s11;
	pp_t         ptw_s13, pra_s13, p840_s13, pt_s17;
	logic [23:0] aq_s4;
	side_t       side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	side_t       side_s11, side_s12, side_s13, side_s14, side_s15;
	side_t       side_s16, side_s17, side_s18, div_side;
	logic [63:0] pbs_s6, rm_s7;
	logic [63:0] r_s8, r_s9, r_s10, r_s11, r_s12;
	logic [63:0] r2_s10;
	logic [63:0] ap_s12, tw_s12, r4_s12, q6_s12, q6_s13, q6_s14;
	logic [63:0] twap_s14, rap_s14, q840_s14;
	logic [DIV_W-1:0] d_s15, n_s15;
	logic [WORK_BITS-1:0] tq;
	logic [63:0] e_s16, t_s16, hi_s18;
	logic [31:0] mant_s19;
	logic [6:0]  sh_s19;

	logic [63:0] rm_mag;
	assign rm_mag = rm_s7[63] ? 64'(-rm_s7) : rm_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
			v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12; v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= div_valid; v_s17 <= v_s16; v_s18 <= v_s17; v_s19 <= v_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: capture the argument.
			x_s1 <= s_tdata[X_WIDTH-1:0];

			// Stage 2: sign and magnitude.
			xneg_s2 <= x_s1[X_WIDTH-1];
			ax_s2   <= x_s1[X_WIDTH-1] ? X_WIDTH'(-x_s1) : x_s1;

			// Stages 3 and 4: Q = trunc(|x| * 16/ln2).
			pa_s3   <= pp_make(64'(ax_s2), K32);
			ax_s3   <= ax_s2;
			xneg_s3 <= xneg_s2;
			aq_s4   <= 24'(pp_sum(pa_s3) >> (32 + INPUT_FRAC_BITS));
			ax_s4   <= ax_s3;
			xneg_s4 <= xneg_s3;

			// Stage 5: Q * ln2/16, plus the table index and shift from Q.
			pb_s5        <= pp_make(64'(aq_s4), C44);
			ax_s5        <= ax_s4;
			xneg_s5      <= xneg_s4;
			side_s5.rneg <= 1'b0;
			side_s5.idx  <= xneg_s4 ? 4'(-aq_s4[3:0]) : aq_s4[3:0];
			side_s5.sh   <= xneg_s4 ? 7'(-((aq_s4 + 24'd15) >> 4)) : 7'(aq_s4 >> 4);

			// Stages 6 to 8: reduced remainder R in sign and magnitude.
			pbs_s6       <= 64'(pp_sum(pb_s5));
			ax_s6        <= ax_s5;
			xneg_s6      <= xneg_s5;
			side_s6      <= side_s5;
			rm_s7        <= (64'(ax_s6) << (RED_BITS - INPUT_FRAC_BITS)) - pbs_s6;
			xneg_s7      <= xneg_s6;
			side_s7      <= side_s6;
			r_s8         <= rm_mag << (WORK_BITS - RED_BITS);
			side_s8.idx  <= side_s7.idx;
			side_s8.sh   <= side_s7.sh;
			side_s8.rneg <= rm_s7[63] ^ xneg_s7;

			// Stages 9 and 10: R^2.
			pr_s9    <= pp_make(r_s8, r_s8);
			r_s9     <= r_s8;
			side_s9  <= side_s8;
			r2_s10   <= 64'(pp_sum(pr_s9) >> WORK_BITS);
			r_s10    <= r_s9;
			side_s10 <= side_s9;

			// Stages 11 and 12: R^2/42, R^2/6, R^4, then a' and 2-R.
			p42_s11  <= pp_make(r2_s10, M42);
			p6_s11   <= pp_make(r2_s10, M6);
			prr_s11  <= pp_make(r2_s10, r2_s10);
			r_s11    <= r_s10;
			side_s11 <= side_s10;
			ap_s12   <= ONE_W + 64'(pp_sum(p42_s11) >> SH42);
			q6_s12   <= 64'(pp_sum(p6_s11) >> SH6);
			r4_s12   <= 64'(pp_sum(prr_s11) >> WORK_BITS);
			tw_s12   <= side_s11.rneg ? (ONE_W << 1) + r_s11 : (ONE_W << 1) - r_s11;
			r_s12    <= r_s11;
			side_s12 <= side_s11;

			// Stages 13 and 14: (2-R)a', R*a', R^4/840.
			ptw_s13  <= pp_make(tw_s12, ap_s12);
			pra_s13  <= pp_make(r_s12, ap_s12);
			p840_s13 <= pp_make(r4_s12, M840);
			q6_s13   <= q6_s12;
			side_s13 <= side_s12;
			twap_s14 <= 64'(pp_sum(ptw_s13) >> WORK_BITS);
			rap_s14  <= 64'(pp_sum(pra_s13) >> WORK_BITS);
			q840_s14 <= 64'(pp_sum(p840_s13) >> SH840);
			q6_s14   <= q6_s13;
			side_s14 <= side_s13;

			// Stage 15: numerator and denominator of the rational term.
			d_s15    <= DIV_W'(twap_s14 + q6_s14 + q840_s14);
			n_s15    <= DIV_W'(rap_s14 << 1);
			side_s15 <= side_s14;

			// Stage 16: e^R and the table entry.
			e_s16    <= div_side.rneg ? ONE_W - 64'(tq) : ONE_W + 64'(tq);
			t_s16    <= ROOT_TAB[div_side.idx];
			side_s16 <= div_side;

			// Stages 17 to 19: product, then round to nearest with ties up.
			pt_s17   <= pp_make(t_s16, e_s16);
			side_s17 <= side_s16;
			hi_s18   <= 64'(pp_sum(pt_s17) >> 64);
			side_s18 <= side_s17;
			mant_s19 <= 32'((hi_s18 + (64'd1 << (RND_SH - 1))) >> RND_SH);
			sh_s19   <= side_s18.sh;
		end
	end

	etra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s15),
		.num      (n_s15),
		.den      (d_s15),
		.in_side  (side_s15),
		.out_valid(div_valid),
		.quo      (tq),
		.out_side (div_side)
	);

	assign m_tvalid = v_s19;
	assign m_tdata  = {1'b0, mant_s19, sh_s19};

	// The rational term's numerator is below its denominator, so the quotient is pure fraction.
	`ASSERT_STD(a_num_below_den, v_s15 |-> n_s15 < d_s15, "rational numerator not below denominator")
	// The reduced remainder stays small after range reduction.
	`ASSERT_STD(a_r_small, v_s8 |-> r_s8 < (64'd1 << (WORK_BITS - 3)), "range reduction left a large remainder")
	// The mantissa never exceeds 2.0.
	`ASSERT_STD(a_mant_range, m_tvalid |-> mant_s19 <= (32'd1 << MANT_FRAC_BITS + 1), "mantissa above 2.0")

endmodule

### tb/exp_result_checker.sv
// Checker that predicts e^x results for each accepted argument and compares the outputs.
module exp_result_checker import etra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [6:0]  power_shift;
		logic [31:0] mantissa;
	} exp_result_t;

	exp_result_t expected_results[$];

	// Restoring division: floor(num * 2^bits / den).
	function automatic logic [127:0] scaled_quotient(logic [127:0] num, logic [127:0] den,
			int bits);
		logic [127:0] q;
		logic [127:0] rem;
		q = num / den;
		rem = num % den;
		for (int i = 0; i < bits; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> WORK_BITS);
	endfunction

	function automatic exp_result_t predict_exp(logic [21:0] x);
		logic [63:0] one_w, ax, k32, c44, aq, r, r2, ap, tw, d, n, tq, e, t;
		logic signed [63:0] rm;
		logic [127:0] prod;
		logic [63:0] roots_dec [16];
		logic xneg, rneg;
		logic [3:0] idx;
		logic signed [63:0] sh;
		exp_result_t res;
		roots_dec = '{64'd100000000000000000, 64'd104427378242741380,
			64'd109050773266525770, 64'd113878863475669160, 64'd118920711500272100,
			64'd124185781207348400, 64'd129683955465100960, 64'd135425554693689270,
			64'd141421356237309510, 64'd147682614593949930, 64'd154221082540794070,
			64'd161049033194925430, 64'd168179283050742900, 64'd175625216037329950,
			64'd183400808640934240, 64'd191520656139714740};
		one_w = 64'd1 << WORK_BITS;
		xneg = x[21];
		ax = xneg ? (64'd1 << 22) - {42'd0, x} : {42'd0, x};
		k32 = 64'(scaled_quotient(128'd23083120654223414, 128'd1000000000000000, 32));
		c44 = 64'(scaled_quotient(128'd43321698784997, 128'd1000000000000000, RED_BITS));
		aq = (ax * k32) >> (32 + INPUT_FRAC_BITS);
		rm = $signed(ax << (RED_BITS - INPUT_FRAC_BITS)) - $signed(aq * c44);
		rneg = (rm < 0) != xneg;
		r = (rm < 0 ? 64'(-rm) : 64'(rm)) << (WORK_BITS - RED_BITS);
		r2 = fixed_mul(r, r);
		ap = one_w + r2 / 42;
		tw = rneg ? 2 * one_w + r : 2 * one_w - r;
		d = fixed_mul(tw, ap) + r2 / 6 + fixed_mul(r2, r2) / 840;
		n = 2 * fixed_mul(r, ap);
		tq = 64'(scaled_quotient({64'd0, n}, {64'd0, d}, WORK_BITS));
		e = rneg ? one_w - tq : one_w + tq;
		if (xneg) begin
			idx = 4'(16 - aq[3:0]);
			sh = -$signed((aq + 15) >> 4);
		end else begin
			idx = aq[3:0];
			sh = $signed(aq >> 4);
		end
		t = 64'(scaled_quotient({64'd0, roots_dec[idx]}, 128'd100000000000000000, TAB_BITS));
		prod = {64'd0, t} * {64'd0, e};
		// The product carries TAB_BITS + WORK_BITS fractional bits; round half up.
		prod = (prod + (128'd1 << (TAB_BITS + WORK_BITS - MANT_FRAC_BITS - 1)))
			>> (TAB_BITS + WORK_BITS - MANT_FRAC_BITS);
		res.power_shift = sh[6:0];
		res.mantissa = prod[31:0];
		return res;
	endfunction

	assign pending_count = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		exp_result_t want;
		exp_result_t got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_exp(s_tdata[21:0]));
			if (m_tvalid && m_tready) begin
				got.power_shift = m_tdata[6:0];
				got.mantissa = m_tdata[38:7];
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result transfer: shift %0d mantissa %h",
							$signed(got.power_shift), got.mantissa);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_tdata[39] !== 1'b0) begin
						if (fail_count < 10)
							$display("Mismatch: shift exp %0d got %0d, mantissa exp %h got %h",
								$signed(want.power_shift), $signed(got.power_shift),
								want.mantissa, got.mantissa);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/testbench.sv
// Top of the e^x pipeline testbench: clock, reset, argument stimulus and verdict.
module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	int          fail_count;
	int          pending_count;
	int          cycle_count = 0;
	// While set, both sides run without gaps or stalls.
	logic        steady = 1'b0;

	always #5 clk = ~clk;

	exp_table_rational_approx dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	exp_result_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// The receiver stalls with a probability of about 23 percent, except during the steady stretch.
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= 23);

	// The whole run, with its stalls and the pipeline latency, fits well inside this bound.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one argument and holds it until the block accepts the transfer.
	task automatic send_argument(logic [21:0] x);
		while (!steady && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Draws an argument from the full range, from within 1000 LSBs of zero, or from [0, 4.0] or [-4.0, 0].
	function automatic logic [21:0] random_argument();
		case ($urandom_range(3))
			0: return 22'($urandom);
			1: return 22'($signed($urandom_range(2000)) - 1000);
			2: return 22'($urandom_range(65536 * 4));
			default: return 22'(-$signed({1'b0, 22'($urandom_range(65536 * 4))}));
		endcase
	endfunction

	initial begin
		logic [21:0] directed [$];
		directed = '{22'h000000, 22'h1fffff, 22'h200000, 22'h000001, 22'h3fffff,
			22'h00b172, 22'h3f4e8e, 22'h010000, 22'h3f0000, 22'h000b17, 22'h3ff4e9,
			22'h0002c6, 22'h3ffd3a, 22'h155555, 22'h2aaaaa, 22'h100000, 22'h300000,
			22'h0fffff, 22'h2fffff, 22'h000f00};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_argument(directed[i]);
		for (int i = 0; i < 400; i++) begin
			steady <= (i >= 150 && i < 230);
			send_argument(random_argument());
		end
		s_tvalid <= 1'b0;
		steady <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
